>>> hdl/quadratic_bezier_sampler_top_macros.svh
// Assertion macros used by the checker file of the curve sampler.
`ifndef QUADRATIC_BEZIER_SAMPLER_TOP_MACROS_SVH
`define QUADRATIC_BEZIER_SAMPLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define QBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define QBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/qbs_pkg.sv
// Package of the curve sampler: field widths, stream packing and sequencer states.
package qbs_pkg;

	localparam int MAX_POINTS = 64;
	localparam int COORD_W    = 24;
	localparam int T_FRAC     = 16;
	localparam int T_W        = T_FRAC + 1;
	localparam int CNT_W      = 7;
	localparam int DIV_W      = 6;
	localparam int DIV_CNT_W  = 5;

	localparam int NUM_COORDS = 6;
	localparam int CNT_LSB    = NUM_COORDS * COORD_W;
	localparam int S_DATA_W   = ((CNT_LSB + CNT_W + 7) / 8) * 8;
	localparam int M_DATA_W   = 2 * COORD_W;

	localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

	// Places of the coordinates within a curve request.
	localparam int PT_START_X = 0;
	localparam int PT_START_Y = 1;
	localparam int PT_STOP_X  = 2;
	localparam int PT_STOP_Y  = 3;
	localparam int PT_CTRL_X  = 4;
	localparam int PT_CTRL_Y  = 5;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} seq_state_t;

endpackage

>>> hdl/quadratic_bezier_sampler_top.sv
// Quadratic curve sampler: a step divider, a sample sequencer and a four-stage evaluation pipeline.
//
// A curve request enters on the s_ group: start, end and control points plus a point count.
// The block answers with point_count samples of the quadratic curve on the m_ group; m_tlast
// marks the final sample. A count of zero gives no samples, a count of one gives the start
// point alone, and a count above 64 is treated as 64.
// s_tready is high only while the sequencer is idle. For a count of two or more, a
// restoring divider first forms the step 1/(count-1), one quotient bit a cycle. The
// sequencer then issues one sample a cycle while the output is not stalled, and each sample
// passes four register stages (weights, weighted products, sums, rounding and clamp) before
// it shows on m_tdata. The next request can be taken while the tail of the previous curve
// drains. The coordinates travel down the pipeline with each sample, so a new curve never
// disturbs samples still in flight.
// While a sample waits with m_tready low, the pipeline and the emitting sequencer freeze;
// no sample is lost or repeated. Reset empties the pipeline and returns the sequencer to idle.
module quadratic_bezier_sampler_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// start_x, start_y, stop_x, stop_y, ctrl_x, ctrl_y, point_count, one zero pad bit
	input  logic [qbs_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// point_x, point_y
	output logic [qbs_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                          m_tlast
);
	import qbs_pkg::*;

	localparam int PROD_W = COORD_W + T_W + 1;
	localparam int ACC_W  = PROD_W + 2;
	localparam int P_W    = ACC_W - T_FRAC;

	seq_state_t state_q, state_d;

	logic                 accept;
	logic                 adv;
	logic [CNT_W-1:0]     cnt_in;
	logic [CNT_W-1:0]     cnt_sat;
	coord_t               crv_q [NUM_COORDS];
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     idx_q;
	logic [DIV_W-1:0]     d_q;
	logic [DIV_W-1:0]     div_rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [T_W-1:0]       step_q;
	logic [T_W-1:0]       t_q;
	logic [DIV_W-1:0]     frac_q;
	logic                 emit;
	logic                 emit_last;
	logic [DIV_W:0]       trial;
	logic                 trial_ge;
	logic [DIV_W:0]       frac_sum;
	logic                 frac_ge;

	logic [T_W-1:0]       u_c;
	logic [2*T_W-1:0]     uu_c, ut_c, tt_c;

	logic                 v_s1, v_s2, v_s3;
	logic                 last_s1, last_s2, last_s3;
	coord_t               crv_s1 [NUM_COORDS];
	logic [2*T_W-1:0]     uu_s1, ut_s1, tt_s1;

	logic signed [T_W:0]    w_c [3];
	logic signed [PROD_W-1:0] prod_c [NUM_COORDS];
	logic signed [PROD_W-1:0] prod_s2 [NUM_COORDS];

	logic signed [ACC_W-1:0] acc_x_c, acc_y_c;
	logic signed [ACC_W-1:0] acc_x_s3, acc_y_s3;

	logic [P_W-1:0]       px_c, py_c;
	coord_t               out_x_c, out_y_c;
	logic                 out_valid_q;
	logic                 out_last_q;
	coord_t               out_x_q, out_y_q;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign cnt_in   = s_tdata[CNT_LSB +: CNT_W];
	assign cnt_sat  = (cnt_in > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : cnt_in;

	assign emit      = (state_q == ST_EMIT) && adv;
	assign emit_last = (idx_q == CNT_W'(n_q - CNT_W'(1)));

	// One restoring step: the dividend is a single one at the top bit position.
	assign trial    = {div_rem_q, (div_cnt_q == DIV_CNT_W'(T_FRAC))};
	assign trial_ge = (trial >= {1'b0, d_q});

	// The fractional part of i/(count-1) gathers here; each overflow adds one to t.
	assign frac_sum = {1'b0, frac_q} + {1'b0, div_rem_q};
	assign frac_ge  = (frac_sum >= {1'b0, d_q});

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cnt_sat == CNT_W'(0)) begin
						state_d = ST_IDLE;
					end else if (cnt_sat == CNT_W'(1)) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(0)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Curve registers, step divider and sample counter.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < NUM_COORDS; k++) begin
				crv_q[k] <= coord_t'(s_tdata[k*COORD_W +: COORD_W]);
			end
			n_q       <= cnt_sat;
			d_q       <= DIV_W'(cnt_sat - CNT_W'(1));
			div_rem_q <= '0;
			div_cnt_q <= DIV_CNT_W'(T_FRAC);
			step_q    <= '0;
			idx_q     <= '0;
			t_q       <= '0;
			frac_q    <= '0;
		end else if (state_q == ST_DIV) begin
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			if (trial_ge) begin
				div_rem_q <= DIV_W'(trial - {1'b0, d_q});
			end else begin
				div_rem_q <= DIV_W'(trial);
			end
			step_q <= {step_q[T_W-2:0], trial_ge};
		end else if (emit) begin
			idx_q <= idx_q + CNT_W'(1);
			if (frac_ge) begin
				frac_q <= DIV_W'(frac_sum - {1'b0, d_q});
				t_q    <= t_q + step_q + T_W'(1);
			end else begin
				frac_q <= DIV_W'(frac_sum);
				t_q    <= t_q + step_q;
			end
		end
	end

	// Stage 1: raw weight products from t and 1 - t.
	assign u_c  = T_ONE - t_q;
	assign uu_c = u_c * u_c;
	assign ut_c = u_c * t_q;
	assign tt_c = t_q * t_q;

	// Stage 2: weights times coordinates.
	assign w_c[0] = $signed({1'b0, uu_s1[T_FRAC +: T_W]});
	assign w_c[1] = $signed({1'b0, ut_s1[T_FRAC-1 +: T_W]});
	assign w_c[2] = $signed({1'b0, tt_s1[T_FRAC +: T_W]});

	always_comb begin
		prod_c[PT_START_X] = crv_s1[PT_START_X] * w_c[0];
		prod_c[PT_START_Y] = crv_s1[PT_START_Y] * w_c[0];
		prod_c[PT_CTRL_X]  = crv_s1[PT_CTRL_X]  * w_c[1];
		prod_c[PT_CTRL_Y]  = crv_s1[PT_CTRL_Y]  * w_c[1];
		prod_c[PT_STOP_X]  = crv_s1[PT_STOP_X]  * w_c[2];
		prod_c[PT_STOP_Y]  = crv_s1[PT_STOP_Y]  * w_c[2];
	end

	// Stage 3: per-axis sums.
	assign acc_x_c = prod_s2[PT_START_X] + prod_s2[PT_CTRL_X] + prod_s2[PT_STOP_X];
	assign acc_y_c = prod_s2[PT_START_Y] + prod_s2[PT_CTRL_Y] + prod_s2[PT_STOP_Y];

	// Stage 4: drop the fraction (floor) and clamp to the coordinate range.
	assign px_c = acc_x_s3[ACC_W-1:T_FRAC];
	assign py_c = acc_y_s3[ACC_W-1:T_FRAC];

	always_comb begin
		if (px_c[P_W-1:COORD_W-1] == '0 || px_c[P_W-1:COORD_W-1] == '1) begin
			out_x_c = coord_t'(px_c[COORD_W-1:0]);
		end else begin
			out_x_c = px_c[P_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end
		if (py_c[P_W-1:COORD_W-1] == '0 || py_c[P_W-1:COORD_W-1] == '1) begin
			out_y_c = coord_t'(py_c[COORD_W-1:0]);
		end else begin
			out_y_c = py_c[P_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= (state_q == ST_EMIT);
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= emit_last;
			uu_s1   <= uu_c;
			ut_s1   <= ut_c;
			tt_s1   <= tt_c;
			for (int k = 0; k < NUM_COORDS; k++) begin
				crv_s1[k]  <= crv_q[k];
				prod_s2[k] <= prod_c[k];
			end
			last_s2    <= last_s1;
			last_s3    <= last_s2;
			acc_x_s3   <= acc_x_c;
			acc_y_s3   <= acc_y_c;
			out_last_q <= last_s3;
			out_x_q    <= out_x_c;
			out_y_q    <= out_y_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_y_q, out_x_q};
	assign m_tlast  = out_last_q;

endmodule

>>> hdl/qbs_checker.sv
// Port-level checker of the curve sampler, bound to the top level.
`include "quadratic_bezier_sampler_top_macros.svh"

module qbs_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [qbs_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [qbs_pkg::M_DATA_W-1:0]  m_tdata,
	input  logic                          m_tlast
);
	import qbs_pkg::*;

	logic req_taken;
	logic req_empty;

	assign req_taken = s_tvalid && s_tready;
	assign req_empty = (s_tdata[CNT_LSB +: CNT_W] == CNT_W'(0));

	// A stalled sample keeps its value and its last mark.
	`QBS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled sample changed")

	// A request with samples to produce closes the input until the curve is issued.
	`QBS_ASSERT_NEXT(a_busy_after_req, req_taken && !req_empty, !s_tready, "input stayed open during a curve")

	// A request for no samples leaves the input open.
	`QBS_ASSERT_NEXT(a_empty_req_idle, req_taken && req_empty, s_tready, "empty request closed the input")

	// Nothing is driven out of reset without a request behind it.
	`QBS_ASSERT_NOW(a_reset_quiet, $rose(arst_n), !m_tvalid, "sample present right after reset")

endmodule

bind quadratic_bezier_sampler_top qbs_checker u_qbs_checker (.*);
